// ----- hw/rtl/pbts_pkg.sv -----
`timescale 1ns / 1ps

package pbts_pkg;

    // field widths fixed by the item format
    localparam int MODE_W   = 3;
    localparam int PRIO_W   = 5;
    localparam int MS_W     = 32;
    localparam int WOKEN_W  = 6;

    // request codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_ADD     = 3'd1,
        MODE_END     = 3'd2,
        MODE_SUSPEND = 3'd3,
        MODE_RESUME  = 3'd4,
        MODE_SLEEP   = 3'd5,
        MODE_STOP    = 3'd6
    } mode_t;

    // per-level task state
    typedef enum logic [1:0] {
        LVL_EMPTY   = 2'd0,
        LVL_ACTIVE  = 2'd1,
        LVL_SUSPEND = 2'd2,
        LVL_SLEEP   = 2'd3
    } lvl_state_t;

    // result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic apply_req;    // apply a non-tick request from the input ports
        logic sweep_start;  // latch tick amount, clear sweep counter
        logic sweep_step;   // advance the sleep sweep by one level
        logic load_result;  // capture the result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_end;    // last level is in the update stage
        logic out_free;     // output register can take a new result
    } dp_stat_t;

endpackage

// ----- hw/rtl/priority_bitmap_task_scheduler_unit.sv -----
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | mode, task_prio, target_prio, amount_ms
// result    | out_valid / out_ready| next_prio, idle, woken_count, status
//
// a request result is loaded in the finish step after acceptance, a tick result after the
// sweep: the tick sweeps the countdown store one level per cycle behind a registered
// read; input is ready again from the loading edge
// one transaction in work at a time, the next taken while the last result waits
// reset (rst_n, asynchronous) empties every level and clears both masks
// a stalled result holds the block in its final step until out_ready

module priority_bitmap_task_scheduler_unit
#(
    parameter int LEVELS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [4:0]  task_prio,
    input  logic [4:0]  target_prio,
    input  logic [31:0] amount_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  next_prio,
    output logic        idle,
    output logic [5:0]  woken_count,
    output logic        status
);
    import pbts_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: idle, sleep sweep, result hand-off
    pbts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // masks, level states, countdown store and output register
    pbts_dp
    #(
        .LEVELS (LEVELS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .task_prio   (task_prio),
        .target_prio (target_prio),
        .amount_ms   (amount_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .next_prio   (next_prio),
        .idle        (idle),
        .woken_count (woken_count),
        .status      (status)
    );

`ifndef NO_ASSERTIONS
    // one transaction at a time: an accepted item blocks the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a transaction is in work");

    // idle result always reports level zero
    a_idle_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && idle) |-> (next_prio == '0))
        else $error("idle result with nonzero level");

    // a refused add is never a tick, so nothing was woken
    a_refused_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_REFUSED)) |-> (woken_count == '0))
        else $error("refused add reports woken tasks");

    // woken count never exceeds the number of levels
    a_woken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({26'd0, woken_count} <= LEVELS))
        else $error("woken count above level count");
`endif

endmodule

// ----- hw/rtl/pbts_ctrl.sv -----
`timescale 1ns / 1ps

module pbts_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2:0]         mode,
    output logic               in_ready,
    input  pbts_pkg::dp_stat_t stat,
    output pbts_pkg::dp_cmd_t  cmd
);
    import pbts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_FIN   = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        cmd.apply_req = 1'b1;
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/pbts_dp.sv -----
`timescale 1ns / 1ps

module pbts_dp
#(
    parameter int LEVELS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pbts_pkg::dp_cmd_t  cmd,
    output pbts_pkg::dp_stat_t stat,
    input  logic [2:0]         mode,
    input  logic [4:0]         task_prio,
    input  logic [4:0]         target_prio,
    input  logic [31:0]        amount_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         next_prio,
    output logic               idle,
    output logic [5:0]         woken_count,
    output logic               status
);
    import pbts_pkg::*;

    localparam int IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(LEVELS + 1);
    localparam logic [PRIO_W:0] LEVELS_LIM = (PRIO_W + 1)'(LEVELS);

    // control state
    logic [LEVELS-1:0] ready_reg,   ready_next;
    logic [LEVELS-1:0] sleep_reg,   sleep_next;
    lvl_state_t        lvl_reg  [LEVELS];
    lvl_state_t        lvl_next [LEVELS];
    logic [CW-1:0]     cnt_reg,     cnt_next;
    logic              pipe_valid_reg;
    logic              out_valid_reg;

    // payload
    logic [IW-1:0]      pipe_idx_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [WOKEN_W-1:0] woken_reg,  woken_next;
    logic               status_reg, status_next;
    logic [MS_W-1:0]    rd_data_reg;
    logic [PRIO_W-1:0]  out_prio_reg;
    logic               out_idle_reg;
    logic [WOKEN_W-1:0] out_woken_reg;
    logic               out_status_reg;

    // sleep countdown store
    logic [MS_W-1:0] sleep_mem [LEVELS];
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    logic [MS_W-1:0] wr_data;

    logic [PRIO_W-1:0] sel_prio;
    logic              sel_ok;
    logic [IW-1:0]     sel_idx;
    lvl_state_t        sel_state;
    logic              sel_used;
    logic              sweep_end;
    logic              pipe_sleep;
    logic [PRIO_W-1:0] enc_prio;

    assign sweep_end      = (cnt_reg == CW'(LEVELS));
    assign stat.sweep_end = sweep_end;
    assign stat.out_free  = !out_valid_reg || out_ready;

    // request target: resume and stop name another level
    always_comb
    begin
        if (mode == MODE_RESUME || mode == MODE_STOP)
        begin
            sel_prio = target_prio;
        end
        else
        begin
            sel_prio = task_prio;
        end
        sel_ok    = ({1'b0, sel_prio} < LEVELS_LIM);
        sel_idx   = sel_prio[IW-1:0];
        sel_state = sel_ok ? lvl_reg[sel_idx] : LVL_EMPTY;
        sel_used  = sel_ok && (sel_state != LVL_EMPTY);
    end

    assign pipe_sleep = pipe_valid_reg && sleep_reg[pipe_idx_reg];

    always_comb
    begin
        ready_next  = ready_reg;
        sleep_next  = sleep_reg;
        lvl_next    = lvl_reg;
        cnt_next    = cnt_reg;
        woken_next  = woken_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = sel_idx;
        wr_data     = amount_ms;

        if (cmd.apply_req)
        begin
            woken_next  = '0;
            status_next = STATUS_OK;
            unique case (mode)
                MODE_ADD:
                begin
                    if (sel_ok)
                    begin
                        if (sel_used)
                        begin
                            status_next = STATUS_REFUSED;
                        end
                        else
                        begin
                            lvl_next[sel_idx]   = LVL_ACTIVE;
                            ready_next[sel_idx] = 1'b1;
                        end
                    end
                end
                MODE_END, MODE_STOP:
                begin
                    if (sel_used)
                    begin
                        lvl_next[sel_idx]   = LVL_EMPTY;
                        ready_next[sel_idx] = 1'b0;
                    end
                end
                MODE_SUSPEND:
                begin
                    if (sel_used)
                    begin
                        lvl_next[sel_idx]   = LVL_SUSPEND;
                        ready_next[sel_idx] = 1'b0;
                    end
                end
                MODE_RESUME:
                begin
                    if (sel_used)
                    begin
                        lvl_next[sel_idx]   = LVL_ACTIVE;
                        ready_next[sel_idx] = 1'b1;
                    end
                end
                MODE_SLEEP:
                begin
                    if (sel_used)
                    begin
                        lvl_next[sel_idx]   = LVL_SLEEP;
                        ready_next[sel_idx] = 1'b0;
                        sleep_next[sel_idx] = 1'b1;
                        wr_en               = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.sweep_start)
        begin
            cnt_next    = '0;
            woken_next  = '0;
            status_next = STATUS_OK;
        end

        if (cmd.sweep_step && !sweep_end)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        // update stage of the sweep, one level behind the read
        if (pipe_sleep)
        begin
            wr_addr = pipe_idx_reg;
            if (lvl_reg[pipe_idx_reg] != LVL_SLEEP)
            begin
                sleep_next[pipe_idx_reg] = 1'b0;
            end
            else if (rd_data_reg > ms_reg)
            begin
                wr_en   = 1'b1;
                wr_data = rd_data_reg - ms_reg;
            end
            else
            begin
                wr_en                    = 1'b1;
                wr_data                  = '0;
                sleep_next[pipe_idx_reg] = 1'b0;
                lvl_next[pipe_idx_reg]   = LVL_ACTIVE;
                ready_next[pipe_idx_reg] = 1'b1;
                woken_next               = woken_reg + WOKEN_W'(1);
            end
        end
    end

    // most urgent ready level
    always_comb
    begin
        enc_prio = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (ready_reg[i])
            begin
                enc_prio = PRIO_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sleep_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= sleep_mem[cnt_reg[IW-1:0]];
        pipe_idx_reg <= cnt_reg[IW-1:0];
        woken_reg    <= woken_next;
        status_reg   <= status_next;
        if (cmd.sweep_start)
        begin
            ms_reg <= amount_ms;
        end
        if (cmd.load_result)
        begin
            out_prio_reg   <= enc_prio;
            out_idle_reg   <= (ready_reg == '0);
            out_woken_reg  <= woken_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg      <= '0;
            sleep_reg      <= '0;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                lvl_reg[i] <= LVL_EMPTY;
            end
        end
        else
        begin
            ready_reg      <= ready_next;
            sleep_reg      <= sleep_next;
            lvl_reg        <= lvl_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= cmd.sweep_step && !sweep_end;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_prio   = out_prio_reg;
    assign idle        = out_idle_reg;
    assign woken_count = out_woken_reg;
    assign status      = out_status_reg;

endmodule
